@@ hdl/kepq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package kepq_pkg;

  localparam int DEPTH      = 256;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MAX_TYPES  = 64;
  localparam int MAX_PEEK   = 64;
  localparam int PAT_W      = 24;
  localparam int TYPE_W     = 6;
  localparam int TIME_W     = 48;
  localparam int SER_W      = 32;
  localparam int NTYPES_W   = 7;
  localparam int PEEK_W     = 7;
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    ACT_PUSH      = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_MODIFY    = 3'd2,
    ACT_POP       = 3'd3,
    ACT_PEEK_ALL  = 3'd4,
    ACT_PEEK_PAT  = 3'd5,
    ACT_QUERY     = 3'd6,
    ACT_NONE      = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_EMPTY   = 3'd1,
    STAT_BADTYPE = 3'd2,
    STAT_NOKEY   = 3'd3,
    STAT_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DO,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    action_t               action;
    logic [PAT_W-1:0]      pat;
    logic [TYPE_W-1:0]     typ;
    logic [TIME_W-1:0]     tm;
    logic                  create;
    logic [PEEK_W-1:0]     want;
    logic                  known;
  } cmd_t;

endpackage
`default_nettype wire

@@ hdl/kepq_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface kepq_req_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    action;
  logic [kepq_pkg::PAT_W-1:0]    patient;
  logic [kepq_pkg::TYPE_W-1:0]   event_type;
  logic [kepq_pkg::TIME_W-1:0]   event_time;
  logic                          create_new;
  logic [kepq_pkg::PEEK_W-1:0]   peek_count;
  modport source (output valid, action, patient, event_type, event_time,
                  create_new, peek_count, input ready);
  modport sink (input valid, action, patient, event_type, event_time,
                create_new, peek_count, output ready);
endinterface

interface kepq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [kepq_pkg::PAT_W-1:0]    out_patient;
  logic [kepq_pkg::TYPE_W-1:0]   out_type;
  logic [kepq_pkg::TIME_W-1:0]   out_time;
  logic [kepq_pkg::CNT_W-1:0]    queue_size;
  logic                          last;
  modport source (output valid, status, out_patient, out_type, out_time,
                  queue_size, last, input ready);
  modport sink (input valid, status, out_patient, out_type, out_time,
                queue_size, last, output ready);
endinterface

interface kepq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kepq_pkg::NTYPES_W-1:0] num_event_types;
  modport source (output valid, num_event_types, input ready);
  modport sink (input valid, num_event_types, output ready);
endinterface
`default_nettype wire

@@ hdl/keyed_event_priority_queue_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload
// req       in   action, patient, event_type, event_time, create_new, peek_count
// rsp       out  status, out_patient, out_type, out_time, queue_size, last
// cfg       in   num_event_types
//
// Every action is one pass over the 256-entry slot memory (one slot per cycle)
// plus an apply step; the next command is taken only after it is applied. A peek
// makes one pass per listed event, plus one that finds no more when the list
// ends short of the count: at most 64 passes.
// rst is synchronous and clears all slot valid bits at once; no clearing pass.
// A two-entry command queue lets the request side run ahead; a stalled rsp
// holds the back end in its apply step.
module keyed_event_priority_queue_top (
  input  wire logic   clk,
  input  wire logic   rst,
  kepq_cfg_if.sink    cfg,
  kepq_req_if.sink    req,
  kepq_rsp_if.source  rsp
);

  kepq_pkg::cmd_t f_cmd;
  kepq_pkg::cmd_t q_cmd;
  logic           f_valid;
  logic           f_ready;
  logic           q_valid;
  logic           q_ready;

  kepq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  kepq_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_cmd   (f_cmd),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_cmd   (q_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  kepq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_cmd   (q_cmd),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .rsp      (rsp)
  );

endmodule
`default_nettype wire

@@ hdl/kepq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kepq_front (
  input  wire logic           clk,
  input  wire logic           rst,
  kepq_cfg_if.sink            cfg,
  kepq_req_if.sink            req,
  output kepq_pkg::cmd_t      cmd,
  output logic                cmd_valid,
  input  wire logic           cmd_ready
);

  logic [kepq_pkg::NTYPES_W-1:0] num_types;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_types <= kepq_pkg::NTYPES_W'(kepq_pkg::MAX_TYPES);
    end else if (cfg.valid) begin
      num_types <= cfg.num_event_types;
    end
  end

  assign req.ready = cmd_ready;
  assign cmd_valid = req.valid;

  always_comb begin
    cmd.action = kepq_pkg::action_t'(req.action);
    cmd.pat    = req.patient;
    cmd.typ    = req.event_type;
    cmd.tm     = req.event_time;
    cmd.create = req.create_new;
    cmd.want   = (req.peek_count > kepq_pkg::PEEK_W'(kepq_pkg::MAX_PEEK)) ?
                 kepq_pkg::PEEK_W'(kepq_pkg::MAX_PEEK) : req.peek_count;
    // type limit is min(register, MAX_TYPES)
    cmd.known  = (num_types > kepq_pkg::NTYPES_W'(kepq_pkg::MAX_TYPES)) ?
                 (kepq_pkg::NTYPES_W'(req.event_type) <
                  kepq_pkg::NTYPES_W'(kepq_pkg::MAX_TYPES)) :
                 (kepq_pkg::NTYPES_W'(req.event_type) < num_types);
  end

endmodule
`default_nettype wire

@@ hdl/kepq_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kepq_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire kepq_pkg::cmd_t wr_cmd,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  output kepq_pkg::cmd_t      rd_cmd,
  output logic                rd_valid,
  input  wire logic           rd_ready
);

  kepq_pkg::cmd_t                 entries [kepq_pkg::FIFO_DEPTH];
  logic [kepq_pkg::FPTR_W-1:0]    wr_ptr;
  logic [kepq_pkg::FPTR_W-1:0]    rd_ptr;
  logic [kepq_pkg::FPTR_W:0]      fill;
  logic                           do_wr;
  logic                           do_rd;

  assign wr_ready = (fill != (kepq_pkg::FPTR_W+1)'(kepq_pkg::FIFO_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_cmd   = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/kepq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kepq_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire kepq_pkg::cmd_t in_cmd,
  input  wire logic           in_valid,
  output logic                in_ready,
  kepq_rsp_if.source          rsp
);

  localparam int IW = kepq_pkg::IDX_W;
  localparam int CW = kepq_pkg::CNT_W;

  typedef struct packed {
    logic [kepq_pkg::PAT_W-1:0]  pat;
    logic [kepq_pkg::TYPE_W-1:0] typ;
    logic [kepq_pkg::TIME_W-1:0] tm;
    logic [kepq_pkg::SER_W-1:0]  ser;
  } ent_t;

  function automatic logic ahead(ent_t a, logic [IW-1:0] ai, ent_t b, logic [IW-1:0] bi);
    ahead = {a.tm, a.typ, a.ser, ai} < {b.tm, b.typ, b.ser, bi};
  endfunction

  ent_t                       slots [kepq_pkg::DEPTH];
  logic [kepq_pkg::DEPTH-1:0] slot_valid;

  kepq_pkg::state_t state, state_next;
  kepq_pkg::cmd_t   cmd;

  logic [CW-1:0]               scan_addr;
  logic                        rd_pend;
  logic [IW-1:0]               rd_idx;
  ent_t                        rd_data;
  logic                        rd_valid;

  logic                        found;
  logic [IW-1:0]               match_idx;
  logic [kepq_pkg::TIME_W-1:0] match_time;
  logic                        free_found;
  logic [IW-1:0]               free_idx;
  logic                        best_v;
  ent_t                        best;
  logic [IW-1:0]               best_idx;
  logic                        pend_v;
  ent_t                        pend;
  logic [IW-1:0]               pend_idx;
  logic [kepq_pkg::PEEK_W-1:0] cnt;
  logic [kepq_pkg::SER_W-1:0]  serial;
  logic [CW-1:0]               vcount;

  logic ofree;
  logic start_cmd;
  logic start_scan;
  logic sel;
  logic is_match;
  logic is_free;

  // back-end control decoded in ST_DO / ST_FLUSH
  logic                        act;
  logic                        emit;
  kepq_pkg::status_t           e_st;
  logic [kepq_pkg::PAT_W-1:0]  e_pat;
  logic [kepq_pkg::TYPE_W-1:0] e_typ;
  logic [kepq_pkg::TIME_W-1:0] e_tm;
  logic                        e_last;
  logic                        wr_en;
  logic [IW-1:0]               wr_idx;
  logic                        set_v;
  logic                        clr_v;
  logic [IW-1:0]               clr_idx;
  logic                        ser_inc;
  logic [CW-1:0]               vcount_new;
  logic                        take_best;
  logic                        want_push;
  kepq_pkg::status_t           push_st;
  logic                        cnt_hit;

  assign ofree     = !rsp.valid || rsp.ready;
  assign in_ready  = (state == kepq_pkg::ST_IDLE);
  assign start_cmd = in_valid && in_ready;
  assign cnt_hit   = (kepq_pkg::PEEK_W'(cnt + 1'b1) == cmd.want);

  // scan compare on registered read data
  always_comb begin
    sel = rd_pend && rd_valid &&
          (cmd.action != kepq_pkg::ACT_PEEK_PAT || rd_data.pat == cmd.pat) &&
          (!pend_v || ahead(pend, pend_idx, rd_data, rd_idx)) &&
          (!best_v || ahead(rd_data, rd_idx, best, best_idx));
    is_match = rd_pend && rd_valid && !found &&
               rd_data.pat == cmd.pat && rd_data.typ == cmd.typ;
    is_free  = rd_pend && !rd_valid && !free_found;
  end

  always_comb begin
    want_push = (cmd.action == kepq_pkg::ACT_PUSH) ||
                (cmd.action == kepq_pkg::ACT_MODIFY && (found || cmd.create));
    if (!cmd.known) begin
      push_st = kepq_pkg::STAT_BADTYPE;
    end else if (found || free_found) begin
      push_st = kepq_pkg::STAT_OK;
    end else begin
      push_st = kepq_pkg::STAT_FULL;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kepq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = kepq_pkg::ST_SCAN;
        end
      end
      kepq_pkg::ST_SCAN: begin
        if (scan_addr[IW] && !rd_pend) begin
          state_next = kepq_pkg::ST_DO;
        end
      end
      kepq_pkg::ST_DO: begin
        if (ofree) begin
          state_next = kepq_pkg::ST_IDLE;
          if ((cmd.action == kepq_pkg::ACT_PEEK_ALL ||
               cmd.action == kepq_pkg::ACT_PEEK_PAT) &&
              cmd.want != '0 && best_v) begin
            state_next = cnt_hit ? kepq_pkg::ST_FLUSH : kepq_pkg::ST_SCAN;
          end
        end
      end
      kepq_pkg::ST_FLUSH: begin
        if (ofree) begin
          state_next = kepq_pkg::ST_IDLE;
        end
      end
      default: state_next = kepq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    act        = 1'b0;
    emit       = 1'b0;
    e_st       = kepq_pkg::STAT_OK;
    e_pat      = '0;
    e_typ      = '0;
    e_tm       = '0;
    e_last     = 1'b1;
    wr_en      = 1'b0;
    wr_idx     = found ? match_idx : free_idx;
    set_v      = 1'b0;
    clr_v      = 1'b0;
    clr_idx    = match_idx;
    ser_inc    = 1'b0;
    vcount_new = vcount;
    take_best  = 1'b0;
    start_scan = start_cmd;
    unique case (state)
      kepq_pkg::ST_DO: begin
        act = ofree;
        unique case (cmd.action) inside
          kepq_pkg::ACT_PUSH, kepq_pkg::ACT_MODIFY: begin
            emit = 1'b1;
            if (want_push) begin
              e_st = push_st;
              if (push_st == kepq_pkg::STAT_OK) begin
                wr_en   = 1'b1;
                ser_inc = 1'b1;
                if (!found) begin
                  set_v      = 1'b1;
                  vcount_new = vcount + 1'b1;
                end
              end
            end else begin
              e_st = kepq_pkg::STAT_NOKEY;
            end
          end
          kepq_pkg::ACT_REMOVE: begin
            emit = 1'b1;
            if (found) begin
              clr_v      = 1'b1;
              vcount_new = vcount - 1'b1;
            end else begin
              e_st = kepq_pkg::STAT_NOKEY;
            end
          end
          kepq_pkg::ACT_POP: begin
            emit = 1'b1;
            if (best_v) begin
              clr_v      = 1'b1;
              clr_idx    = best_idx;
              vcount_new = vcount - 1'b1;
              e_pat      = best.pat;
              e_typ      = best.typ;
              e_tm       = best.tm;
            end else begin
              e_st = kepq_pkg::STAT_EMPTY;
            end
          end
          kepq_pkg::ACT_PEEK_ALL, kepq_pkg::ACT_PEEK_PAT: begin
            if (cmd.want == '0) begin
              emit = 1'b1;
              e_st = kepq_pkg::STAT_EMPTY;
            end else if (best_v) begin
              // hold this one back until we know whether it is the final item
              emit       = pend_v;
              e_last     = 1'b0;
              e_pat      = pend.pat;
              e_typ      = pend.typ;
              e_tm       = pend.tm;
              take_best  = 1'b1;
              start_scan = ofree && !cnt_hit;
            end else begin
              emit = 1'b1;
              if (pend_v) begin
                e_pat = pend.pat;
                e_typ = pend.typ;
                e_tm  = pend.tm;
              end else begin
                e_st = kepq_pkg::STAT_EMPTY;
              end
            end
          end
          kepq_pkg::ACT_QUERY: begin
            emit = 1'b1;
            if (found) begin
              e_pat = cmd.pat;
              e_typ = cmd.typ;
              e_tm  = match_time;
            end else begin
              e_st = kepq_pkg::STAT_NOKEY;
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      kepq_pkg::ST_FLUSH: begin
        act   = ofree;
        emit  = 1'b1;
        e_pat = pend.pat;
        e_typ = pend.typ;
        e_tm  = pend.tm;
      end
      default: ;
    endcase
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (act && wr_en) begin
      slots[wr_idx] <= '{pat: cmd.pat, typ: cmd.typ, tm: cmd.tm, ser: serial};
    end
    rd_data  <= slots[scan_addr[IW-1:0]];
    rd_valid <= slot_valid[scan_addr[IW-1:0]];
    rd_idx   <= scan_addr[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kepq_pkg::ST_IDLE;
      slot_valid <= '0;
      serial     <= '0;
      vcount     <= '0;
      rd_pend    <= 1'b0;
      scan_addr  <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      best_v     <= 1'b0;
      pend_v     <= 1'b0;
      cnt        <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (act && emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (start_cmd) begin
        cmd    <= in_cmd;
        pend_v <= 1'b0;
        cnt    <= '0;
      end
      if (start_scan) begin
        scan_addr  <= '0;
        rd_pend    <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
        best_v     <= 1'b0;
      end else if (state == kepq_pkg::ST_SCAN) begin
        rd_pend <= !scan_addr[IW];
        if (!scan_addr[IW]) begin
          scan_addr <= scan_addr + 1'b1;
        end
        if (is_match) begin
          found      <= 1'b1;
          match_idx  <= rd_idx;
          match_time <= rd_data.tm;
        end
        if (is_free) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
        if (sel) begin
          best_v   <= 1'b1;
          best     <= rd_data;
          best_idx <= rd_idx;
        end
      end
      if (act) begin
        if (set_v) begin
          slot_valid[wr_idx] <= 1'b1;
        end
        if (clr_v) begin
          slot_valid[clr_idx] <= 1'b0;
        end
        if (ser_inc) begin
          serial <= serial + 1'b1;
        end
        vcount <= vcount_new;
        if (take_best) begin
          pend_v   <= 1'b1;
          pend     <= best;
          pend_idx <= best_idx;
          cnt      <= cnt + 1'b1;
        end
        if (emit) begin
          rsp.status      <= e_st;
          rsp.out_patient <= e_pat;
          rsp.out_type    <= e_typ;
          rsp.out_time    <= e_tm;
          rsp.queue_size  <= vcount_new;
          rsp.last        <= e_last;
        end
      end
    end
  end

endmodule
`default_nettype wire
